FILE: hw/rtl/wpm_pkg.sv
`default_nettype none

package wpm_pkg;

  localparam logic [7:0] SYM_STAR = 8'd42;
  localparam logic [7:0] SYM_ANY  = 8'd63;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/wildcard_pattern_matcher.sv
`default_nettype none

// Channel | Ports                                   | Moves
// --------+-----------------------------------------+----------------------------------
// in      | in_valid, in_ready, in_op, in_symbol,   | one pattern or text byte per
//         | in_first                                | request
// out     | out_valid, out_ready, out_matched,      | one match result per input
//         | out_pattern_overflow                    | request
//
// A request is accepted into the input register, and its result then goes into the result
// register: the position update runs in one pass between the two registers.
// A new request is accepted every cycle while results are taken, because the input register
// hands its request on in the same cycle that it takes the next one.
// Reset (rst_n low at a clock edge) empties both registers, clears the pattern length and
// the overflow flag, and leaves only position zero active. The pattern store keeps its data.
// When out_ready is low the result holds and the input register fills, then in_ready drops.
module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_PAT = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_pattern_overflow
);

  localparam int W     = MAX_PAT + 1;
  localparam int LEN_W = $clog2(MAX_PAT + 1);
  localparam int LVLS  = (W > 2) ? $clog2(W) : 1;

  logic             s1_valid_r;
  logic             s1_op_r;
  logic [7:0]       s1_sym_r;
  logic             s1_first_r;

  logic             out_valid_r;
  logic             out_matched_r;
  logic             out_ovf_r;

  logic [7:0]       store_r [MAX_PAT];
  logic [MAX_PAT-1:0] star_r;
  logic [MAX_PAT-1:0] any_r;
  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic [W-1:0]     active_r;
  logic [W-1:0]     init_r;

  logic             adv;
  logic             fire;
  logic             load_en;

  logic [LEN_W-1:0] len_base;
  logic             room;
  logic [LEN_W-1:0] load_len;
  logic [MAX_PAT-1:0] load_star;
  logic [MAX_PAT-1:0] load_mask;
  logic [W-1:0]     load_set;

  logic [MAX_PAT-1:0] text_mask;
  logic [W-1:0]     base_set;
  logic [MAX_PAT-1:0] stay;
  logic [MAX_PAT-1:0] move;
  logic [W-1:0]     step_set;
  logic [W-1:0]     text_set;

  logic [LEN_W-1:0] len_nxt;
  logic             ovf_nxt;
  logic [W-1:0]     active_nxt;
  logic [W-1:0]     init_nxt;
  logic             matched_nxt;

  // A set position moves across a run of stars; prefix doubling keeps the chain short.
  function automatic logic [W-1:0] closure(input logic [W-1:0] set,
                                           input logic [MAX_PAT-1:0] prop);
    logic [W-1:0] x;
    logic [W-1:0] q;
    int           sh;
    x  = set;
    q  = {prop, 1'b0};
    sh = 1;
    for (int l = 0; l < LVLS; l++) begin
      x  = x | ((x << sh) & q);
      q  = q & (q << sh);
      sh = sh * 2;
    end
    return x;
  endfunction

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  assign len_base = s1_first_r ? '0 : len_r;
  assign room     = len_base < LEN_W'(MAX_PAT);
  assign load_len = room ? len_base + LEN_W'(1) : len_base;
  assign load_en  = fire && (s1_op_r == OP_PATTERN) && room;

  always_comb begin
    for (int i = 0; i < MAX_PAT; i++) begin
      load_star[i] = (room && len_base == LEN_W'(i)) ? (s1_sym_r == SYM_STAR) : star_r[i];
      load_mask[i] = LEN_W'(i) < load_len;
      text_mask[i] = LEN_W'(i) < len_r;
    end
  end

  assign load_set = closure(W'(1), load_star & load_mask);

  assign base_set = s1_first_r ? init_r : active_r;

  always_comb begin
    for (int i = 0; i < MAX_PAT; i++) begin
      stay[i] = base_set[i] && text_mask[i] && star_r[i];
      move[i] = base_set[i] && text_mask[i] && !star_r[i]
                && (any_r[i] || store_r[i] == s1_sym_r);
    end
  end

  assign step_set = {1'b0, stay} | {move, 1'b0};
  assign text_set = closure(step_set, star_r & text_mask);

  always_comb begin
    if (s1_op_r == OP_PATTERN) begin
      len_nxt     = load_len;
      ovf_nxt     = (s1_first_r ? 1'b0 : ovf_r) || !room;
      active_nxt  = load_set;
      init_nxt    = load_set;
      matched_nxt = load_set[load_len];
    end else begin
      len_nxt     = len_r;
      ovf_nxt     = ovf_r;
      active_nxt  = text_set;
      init_nxt    = init_r;
      matched_nxt = text_set[len_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      active_r    <= W'(1);
      init_r      <= W'(1);
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        len_r       <= len_nxt;
        ovf_r       <= ovf_nxt;
        active_r    <= active_nxt;
        init_r      <= init_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_op;
      s1_sym_r   <= in_symbol;
      s1_first_r <= in_first;
    end
    if (fire) begin
      out_matched_r <= matched_nxt;
      out_ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PAT; i++) begin
      if (load_en && len_base == LEN_W'(i)) begin
        store_r[i] <= s1_sym_r;
        star_r[i]  <= (s1_sym_r == SYM_STAR);
        any_r[i]   <= (s1_sym_r == SYM_ANY);
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PAT))
    else $error("pattern length beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == LEN_W'(MAX_PAT))
    else $error("overflow flagged while the store has room");

  a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
    init_r[0])
    else $error("start set lost position zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("request held across reset");

endmodule

`default_nettype wire

FILE: dv/tb_wildcard_pattern_matcher.sv
`timescale 1ns / 100ps

module tb_wildcard_pattern_matcher
  import wpm_pkg::*;
();

  localparam int MAX_PAT = 32;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;
  localparam int LONG_HOLD_CYCLES = 60;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_rsp_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = OP_PATTERN;
  logic [7:0] in_symbol = 8'd0;
  logic       in_first = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_matched;
  logic       out_pattern_overflow;

  wildcard_pattern_matcher #(
    .MAX_PAT(MAX_PAT)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_symbol            (in_symbol),
    .in_first             (in_first),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow)
  );

  match_rsp_t       expected_matches[$];
  logic [7:0]       pat_mem[MAX_PAT];
  int unsigned      pat_len = 0;
  logic [MAX_PAT:0] live_pos = (MAX_PAT + 1)'(1);
  logic             pat_ovf = 1'b0;
  int               err_count = 0;
  int               reqs_sent = 0;
  bit               src_idle_on = 1'b1;
  bit               sink_idle_on = 1'b1;
  bit               long_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_wildcard_pattern_matcher: errors");
    $finish;
  end

  function automatic logic [MAX_PAT:0] close_stars(logic [MAX_PAT:0] s);
    for (int i = 0; i < pat_len; i++) begin
      if (s[i] && pat_mem[i] == SYM_STAR) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic match_rsp_t predict_match(logic op, logic [7:0] sym, logic first);
    logic [MAX_PAT:0] nxt;
    match_rsp_t       rsp;
    if (op == OP_PATTERN) begin
      if (first) begin
        pat_len = 0;
        pat_ovf = 1'b0;
      end
      if (pat_len < MAX_PAT) begin
        pat_mem[pat_len] = sym;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      live_pos = close_stars((MAX_PAT + 1)'(1));
    end else begin
      if (first) begin
        live_pos = close_stars((MAX_PAT + 1)'(1));
      end
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (live_pos[i]) begin
          if (pat_mem[i] == SYM_STAR) begin
            nxt[i] = 1'b1;
          end else if (pat_mem[i] == SYM_ANY || pat_mem[i] == sym) begin
            nxt[i+1] = 1'b1;
          end
        end
      end
      live_pos = close_stars(nxt);
    end
    rsp.matched  = live_pos[pat_len];
    rsp.overflow = pat_ovf;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    match_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("result with no pending request", out_matched, 0);
      end else begin
        want = expected_matches.pop_front();
        if (out_matched !== want.matched) begin
          report_mismatch("matched", out_matched, want.matched);
        end
        if (out_pattern_overflow !== want.overflow) begin
          report_mismatch("pattern_overflow", out_pattern_overflow, want.overflow);
        end
      end
    end
  end

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(logic op, logic [7:0] sym, logic first);
    int gap;
    in_valid  <= 1'b1;
    in_op     <= op;
    in_symbol <= sym;
    in_first  <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_matches.push_back(predict_match(op, sym, first));
    reqs_sent++;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_expected();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CH_A;
    if (r < 8) return CH_B;
    if (r == 8) return CH_C;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_pattern_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return CH_A;
    if (r < 5) return CH_B;
    if (r < 7) return SYM_STAR;
    if (r == 7) return SYM_ANY;
    if (r == 8) return CH_C;
    return 8'($urandom_range(0, 255));
  endfunction

  // A pattern is loaded and then one to three texts are streamed against it. Most texts are
  // built to fit the pattern and some of them are then broken by one edit.
  task automatic run_one_sequence(int min_len, int max_len);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         len;
    int         n_texts;
    int         idx;
    len = $urandom_range(min_len, max_len);
    for (int i = 0; i < len; i++) begin
      pat.push_back(pick_pattern_sym());
      send_req(OP_PATTERN, pat[i], i == 0);
    end
    n_texts = $urandom_range(1, 3);
    repeat (n_texts) begin
      txt.delete();
      foreach (pat[i]) begin
        if (pat[i] == SYM_STAR) begin
          repeat ($urandom_range(0, 3)) txt.push_back(pick_text_sym());
        end else if (pat[i] == SYM_ANY) begin
          txt.push_back(pick_text_sym());
        end else begin
          txt.push_back(pat[i]);
        end
      end
      if ($urandom_range(0, 2) == 0 && txt.size() != 0) begin
        idx = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: txt[idx] = pick_text_sym();
          1: txt.delete(idx);
          default: txt.push_back(pick_text_sym());
        endcase
      end
      if (txt.size() == 0) begin
        txt.push_back(pick_text_sym());
      end
      foreach (txt[i]) begin
        send_req(OP_TEXT, txt[i], i == 0);
      end
    end
  endtask

  task automatic test_directed();
    send_req(OP_TEXT, CH_A, 1'b1);
    send_req(OP_TEXT, 8'd0, 1'b0);
    send_req(OP_TEXT, 8'd255, 1'b1);
    send_req(OP_PATTERN, SYM_STAR, 1'b1);
    send_req(OP_PATTERN, SYM_ANY, 1'b0);
    send_req(OP_PATTERN, CH_A, 1'b0);
    send_req(OP_TEXT, 8'd255, 1'b1);
    send_req(OP_TEXT, CH_A, 1'b0);
    send_req(OP_TEXT, CH_B, 1'b0);
    send_req(OP_TEXT, CH_A, 1'b0);
    send_req(OP_PATTERN, 8'd0, 1'b1);
    send_req(OP_TEXT, 8'd0, 1'b1);
    send_req(OP_TEXT, 8'd255, 1'b0);
    send_req(OP_TEXT, 8'd0, 1'b0);
    send_req(OP_PATTERN, 8'd255, 1'b1);
    send_req(OP_PATTERN, SYM_STAR, 1'b0);
    send_req(OP_TEXT, 8'd255, 1'b1);
    send_req(OP_TEXT, 8'd0, 1'b0);
    send_req(OP_TEXT, 8'd255, 1'b0);
    send_req(OP_PATTERN, SYM_ANY, 1'b1);
    send_req(OP_TEXT, SYM_STAR, 1'b1);
    send_req(OP_TEXT, SYM_ANY, 1'b0);
  endtask

  task automatic test_random_sequences(int n_reqs);
    int stop_at;
    stop_at = reqs_sent + n_reqs;
    while (reqs_sent < stop_at) begin
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0);
        end
      end else if ($urandom_range(0, 9) == 0) begin
        run_one_sequence(9, MAX_PAT);
      end else begin
        run_one_sequence(1, 8);
      end
    end
  endtask

  task automatic test_pattern_overflow();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (3) run_one_sequence(MAX_PAT + 1, MAX_PAT + 6);
    run_one_sequence(1, 4);
  endtask

  task automatic test_long_stall();
    src_idle_on = 1'b0;
    long_hold   = 1'b1;
    repeat (30) begin
      send_req(1'($urandom_range(0, 1)), pick_pattern_sym(), $urandom_range(0, 5) == 0);
    end
    in_valid <= 1'b0;
    while (long_hold) @(posedge clk);
  endtask

  task automatic test_drain_pause();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    run_one_sequence(2, 6);
    drain_expected();
    run_one_sequence(2, 6);
  endtask

  task automatic test_idle_free_tail(int n_reqs);
    int stop_at;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    stop_at = reqs_sent + n_reqs;
    while (reqs_sent < stop_at) begin
      run_one_sequence(1, 8);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sequences(400);
    test_pattern_overflow();
    test_long_stall();
    test_drain_pause();
    test_random_sequences(400);
    test_idle_free_tail(200);
    drain_expected();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_wildcard_pattern_matcher: clean");
    end else begin
      $display("tb_wildcard_pattern_matcher: errors");
    end
    $finish;
  end

endmodule

FILE: wildcard_pattern_matcher.f
hw/rtl/wpm_pkg.sv
hw/rtl/wildcard_pattern_matcher.sv
dv/tb_wildcard_pattern_matcher.sv
